[hdl/fen_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FEN parser package
// Shared constants, character codes and the piece and castle letter decodes.
// ----------------------------------------------------------------------------
package fen_pkg;

	localparam int CLOCK_BITS_DEF = 16;
	localparam int CH_W           = 8;
	localparam int SLOT_W         = 7;
	localparam int PIECE_W        = 4;
	localparam int SQ_W           = 6;
	localparam int CASTLE_W       = 4;
	localparam int EP_W           = 7;
	localparam int CLK_OUT_W      = 16;
	localparam int RES_BITS       = SLOT_W + PIECE_W + SQ_W + 1 + CASTLE_W + EP_W
	                                + 2 * CLK_OUT_W + SLOT_W;
	localparam int TDATA_W        = ((RES_BITS + 7) / 8) * 8;

	localparam logic [SLOT_W-1:0] SLOT_WKING = 7'd0;
	localparam logic [SLOT_W-1:0] SLOT_BKING = 7'd1;
	localparam logic [SLOT_W-1:0] SLOT_FIRST = 7'd2;
	localparam logic [SLOT_W-1:0] SLOT_LIMIT = 7'd65;

	localparam logic [PIECE_W-1:0] PC_NONE  = 4'd0;
	localparam logic [PIECE_W-1:0] PC_WKING = 4'd1;
	localparam logic [PIECE_W-1:0] PC_BKING = 4'd7;

	localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CH_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [CH_W-1:0] CH_0     = 8'h30;
	localparam logic [CH_W-1:0] CH_1     = 8'h31;
	localparam logic [CH_W-1:0] CH_8     = 8'h38;
	localparam logic [CH_W-1:0] CH_9     = 8'h39;
	localparam logic [CH_W-1:0] CH_A_LO  = 8'h61;
	localparam logic [CH_W-1:0] CH_H_LO  = 8'h68;

	localparam logic [CASTLE_W-1:0] CAS_WK = 4'd1;
	localparam logic [CASTLE_W-1:0] CAS_WQ = 4'd2;
	localparam logic [CASTLE_W-1:0] CAS_BK = 4'd4;
	localparam logic [CASTLE_W-1:0] CAS_BQ = 4'd8;

	// piece code: position in "_KQRBNPkqrbnp", 0 when not a piece letter
	function automatic logic [PIECE_W-1:0] piece_code(input logic [CH_W-1:0] c);
		logic [PIECE_W-1:0] r;
		case (c)
			"K": r = 4'd1;
			"Q": r = 4'd2;
			"R": r = 4'd3;
			"B": r = 4'd4;
			"N": r = 4'd5;
			"P": r = 4'd6;
			"k": r = 4'd7;
			"q": r = 4'd8;
			"r": r = 4'd9;
			"b": r = 4'd10;
			"n": r = 4'd11;
			"p": r = 4'd12;
			default: r = PC_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [CASTLE_W-1:0] castle_code(input logic [CH_W-1:0] c);
		logic [CASTLE_W-1:0] r;
		case (c)
			"K": r = CAS_WK;
			"Q": r = CAS_WQ;
			"k": r = CAS_BK;
			"q": r = CAS_BQ;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[hdl/fen_position_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FEN position parser
// Streams a FEN record one character per request; emits one placement
// request per board piece letter and one summary request on the closing NUL.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                        | tuser
//  s_axis   | in  | ch[7:0]                      | -
//  m_axis   | out | slot,piece,square,player,    | kind
//           |     | castle,ep_square,fifty,      |
//           |     | fullmove,list_end, pad       |
//
//  One character per cycle while s_axis_tready is high; the result register is
//  loaded at the edge that takes the character unless it holds a waiting result.
//  A two-entry output (result register plus skid) lets input flow on while
//  a result waits; s_axis_tready drops only when both hold results.
//  arst_n clears parser state and both output entries.
// ----------------------------------------------------------------------------
module fen_position_parser
	import fen_pkg::*;
#(
	parameter int CLOCK_BITS = CLOCK_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [CH_W-1:0]    s_axis_tdata,   // [7:0] ch
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,   // slot, piece, square, player, castle,
	                                           // ep_square, fifty, fullmove,
	                                           // list_end, zero pad
	output logic               m_axis_tuser    // kind
);

	localparam int ACC_W = CLOCK_BITS + 4;
	localparam logic [CLOCK_BITS-1:0] CLK_MAX = '1;

	typedef enum logic [3:0] {
		PH_PLACE, PH_SEP, PH_SIDE, PH_SIDE_SKIP, PH_CAS_FIRST, PH_CAS_MORE,
		PH_CAS_DASH, PH_EP_FIRST, PH_EP_RANK, PH_EP_SKIP, PH_CLK_FIRST,
		PH_CLK_SECOND, PH_FIFTY_DIG, PH_MOVE_WS, PH_MOVE_DIG, PH_IGNORE
	} phase_t;

	phase_t                  phase_q, phase_d;
	logic [2:0]              rank_q, rank_d;
	logic [3:0]              file_q, file_d;
	logic [SLOT_W-1:0]       slot_q, slot_d;
	logic                    side_q, side_d;
	logic [CASTLE_W-1:0]     castle_q, castle_d;
	logic [EP_W-1:0]         ep_q, ep_d;
	logic [CLOCK_BITS-1:0]   fifty_q, fifty_d;
	logic [CLOCK_BITS-1:0]   move_q, move_d;
	logic                    neg_q, neg_d;
	logic                    seen_q, seen_d;
	logic                    cvalid_q, cvalid_d;

	logic                    out_valid_q, skid_valid_q;
	logic [TDATA_W-1:0]      out_data_q, skid_data_q;
	logic                    out_kind_q, skid_kind_q;

	logic                    accept;
	logic                    res_valid;
	logic                    res_kind;
	logic [TDATA_W-1:0]      res_data;

	logic [PIECE_W-1:0]      pc;
	logic [CASTLE_W-1:0]     cas;
	logic                    is_dig, is_spc, is_file, is_rank18;
	logic [3:0]              dig_val;
	logic [CLOCK_BITS-1:0]   dig_ext;
	logic [CLOCK_BITS-1:0]   fifty_add, move_add;
	logic [ACC_W-1:0]        fifty_prod, move_prod;
	logic [CLOCK_BITS-1:0]   fifty_sum, move_sum;
	logic [CLOCK_BITS+CLK_OUT_W-1:0] fifty_ext, move_ext;
	logic [SLOT_W-1:0]       p_slot;
	logic [SQ_W-1:0]         p_square;
	logic [2:0]              ep_rank;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !skid_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;

	assign pc        = piece_code(s_axis_tdata);
	assign cas       = castle_code(s_axis_tdata);
	assign is_dig    = (s_axis_tdata >= CH_0) && (s_axis_tdata <= CH_9);
	assign is_spc    = (s_axis_tdata == CH_SPACE) ||
	                   ((s_axis_tdata >= CH_TAB) && (s_axis_tdata <= CH_CR));
	assign is_file   = (s_axis_tdata >= CH_A_LO) && (s_axis_tdata <= CH_H_LO);
	assign is_rank18 = (s_axis_tdata >= CH_1) && (s_axis_tdata <= CH_8);
	assign dig_val   = 4'(s_axis_tdata - CH_0);
	assign dig_ext   = CLOCK_BITS'(dig_val);
	assign ep_rank   = is_rank18 ? 3'(s_axis_tdata - CH_1) : 3'd0;

	// acc*10 + digit, saturating
	assign fifty_prod = (ACC_W'(fifty_q) << 3) + (ACC_W'(fifty_q) << 1) + ACC_W'(dig_val);
	assign move_prod  = (ACC_W'(move_q) << 3) + (ACC_W'(move_q) << 1) + ACC_W'(dig_val);
	assign fifty_add  = (fifty_prod[ACC_W-1:CLOCK_BITS] != '0) ? CLK_MAX
	                                                           : fifty_prod[CLOCK_BITS-1:0];
	assign move_add   = (move_prod[ACC_W-1:CLOCK_BITS] != '0) ? CLK_MAX
	                                                          : move_prod[CLOCK_BITS-1:0];

	assign fifty_sum = cvalid_q ? fifty_q : '0;
	assign move_sum  = (cvalid_q && seen_q && !neg_q && (move_q != '0))
	                   ? move_q : CLOCK_BITS'(1);
	assign fifty_ext = {{CLK_OUT_W{1'b0}}, fifty_sum};
	assign move_ext  = {{CLK_OUT_W{1'b0}}, move_sum};

	assign p_slot   = (pc == PC_WKING) ? SLOT_WKING :
	                  (pc == PC_BKING) ? SLOT_BKING : slot_q;
	assign p_square = {rank_q, file_q[2:0]};

	always_comb begin
		phase_d  = phase_q;
		rank_d   = rank_q;
		file_d   = file_q;
		slot_d   = slot_q;
		side_d   = side_q;
		castle_d = castle_q;
		ep_d     = ep_q;
		fifty_d  = fifty_q;
		move_d   = move_q;
		neg_d    = neg_q;
		seen_d   = seen_q;
		cvalid_d = cvalid_q;
		res_valid = 1'b0;
		res_kind  = 1'b0;
		res_data  = '0;

		if (s_axis_tdata == CH_NUL) begin
			res_valid = 1'b1;
			res_kind  = 1'b1;
			res_data  = TDATA_W'({slot_q, move_ext[CLK_OUT_W-1:0], fifty_ext[CLK_OUT_W-1:0],
			                      ep_q, castle_q, side_q, {SQ_W{1'b0}}, PC_NONE, slot_q});
			phase_d  = PH_PLACE;
			rank_d   = 3'd7;
			file_d   = '0;
			slot_d   = SLOT_FIRST;
			side_d   = 1'b0;
			castle_d = '0;
			ep_d     = '0;
			fifty_d  = '0;
			move_d   = '0;
			neg_d    = 1'b0;
			seen_d   = 1'b0;
			cvalid_d = 1'b0;
		end else begin
			case (phase_q)
				PH_PLACE: begin
					if (pc != PC_NONE) begin
						res_valid = 1'b1;
						res_data  = TDATA_W'({p_square, pc, p_slot});
						if (pc != PC_WKING && pc != PC_BKING && slot_q < SLOT_LIMIT)
							slot_d = slot_q + 7'd1;
						file_d = file_q + 4'd1;
					end else if (is_rank18) begin
						file_d = file_q + dig_val;
					end else begin
						file_d = file_q + 4'd1;
					end
					if (file_d[3])
						phase_d = PH_SEP;
				end
				PH_SEP: begin
					if (rank_q == 3'd0) begin
						phase_d = PH_SIDE;
					end else begin
						rank_d  = rank_q - 3'd1;
						file_d  = '0;
						phase_d = PH_PLACE;
					end
				end
				PH_SIDE: begin
					if (s_axis_tdata == "W" || s_axis_tdata == "w")
						side_d = 1'b0;
					else if (s_axis_tdata == "B" || s_axis_tdata == "b")
						side_d = 1'b1;
					phase_d = PH_SIDE_SKIP;
				end
				PH_SIDE_SKIP: phase_d = PH_CAS_FIRST;
				PH_CAS_FIRST: begin
					if (s_axis_tdata == CH_DASH) begin
						phase_d = PH_CAS_DASH;
					end else if (cas != '0) begin
						castle_d = castle_q | cas;
						phase_d  = PH_CAS_MORE;
					end else begin
						phase_d = PH_EP_FIRST;
					end
				end
				PH_CAS_MORE: begin
					if (cas != '0)
						castle_d = castle_q | cas;
					else
						phase_d = PH_EP_FIRST;
				end
				PH_CAS_DASH: phase_d = PH_EP_FIRST;
				PH_EP_FIRST: begin
					if (s_axis_tdata == CH_DASH) begin
						ep_d    = '0;
						phase_d = PH_EP_SKIP;
					end else begin
						ep_d    = is_file ? EP_W'(s_axis_tdata - CH_A_LO) : '0;
						phase_d = PH_EP_RANK;
					end
				end
				PH_EP_RANK: begin
					ep_d    = ep_q + {ep_rank, 4'b0000};
					phase_d = PH_EP_SKIP;
				end
				PH_EP_SKIP: phase_d = PH_CLK_FIRST;
				PH_CLK_FIRST: begin
					if (is_dig) begin
						fifty_d = dig_ext;
						phase_d = PH_CLK_SECOND;
					end else begin
						phase_d = PH_IGNORE;
					end
				end
				PH_CLK_SECOND: begin
					if (is_dig) begin
						cvalid_d = 1'b1;
						fifty_d  = fifty_add;
						phase_d  = PH_FIFTY_DIG;
					end else if (s_axis_tdata == CH_SPACE) begin
						cvalid_d = 1'b1;
						phase_d  = PH_MOVE_WS;
					end else begin
						phase_d = PH_IGNORE;
					end
				end
				PH_FIFTY_DIG: begin
					if (is_dig)
						fifty_d = fifty_add;
					else if (is_spc)
						phase_d = PH_MOVE_WS;
					else
						phase_d = PH_IGNORE;
				end
				PH_MOVE_WS: begin
					if (is_spc) begin
						phase_d = PH_MOVE_WS;
					end else if (s_axis_tdata == CH_PLUS) begin
						phase_d = PH_MOVE_DIG;
					end else if (s_axis_tdata == CH_DASH) begin
						neg_d   = 1'b1;
						phase_d = PH_MOVE_DIG;
					end else if (is_dig) begin
						move_d  = dig_ext;
						seen_d  = 1'b1;
						phase_d = PH_MOVE_DIG;
					end else begin
						phase_d = PH_IGNORE;
					end
				end
				PH_MOVE_DIG: begin
					if (is_dig) begin
						move_d = move_add;
						seen_d = 1'b1;
					end else begin
						phase_d = PH_IGNORE;
					end
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_PLACE;
			rank_q       <= 3'd7;
			file_q       <= '0;
			slot_q       <= SLOT_FIRST;
			side_q       <= 1'b0;
			castle_q     <= '0;
			ep_q         <= '0;
			fifty_q      <= '0;
			move_q       <= '0;
			neg_q        <= 1'b0;
			seen_q       <= 1'b0;
			cvalid_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			out_data_q   <= '0;
			out_kind_q   <= 1'b0;
			skid_data_q  <= '0;
			skid_kind_q  <= 1'b0;
		end else begin
			if (accept) begin
				phase_q  <= phase_d;
				rank_q   <= rank_d;
				file_q   <= file_d;
				slot_q   <= slot_d;
				side_q   <= side_d;
				castle_q <= castle_d;
				ep_q     <= ep_d;
				fifty_q  <= fifty_d;
				move_q   <= move_d;
				neg_q    <= neg_d;
				seen_q   <= seen_d;
				cvalid_q <= cvalid_d;
			end
			if (skid_valid_q) begin
				if (m_axis_tready) begin
					skid_valid_q <= 1'b0;
					out_data_q   <= skid_data_q;
					out_kind_q   <= skid_kind_q;
				end
			end else if (accept && res_valid) begin
				if (out_valid_q && !m_axis_tready) begin
					skid_valid_q <= 1'b1;
					skid_data_q  <= res_data;
					skid_kind_q  <= res_kind;
				end else begin
					out_valid_q <= 1'b1;
					out_data_q  <= res_data;
					out_kind_q  <= res_kind;
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without a result in the output register");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
		else $error("skid loaded while output was free");

	a_summary_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q) |->
		(out_data_q[SLOT_W+PIECE_W-1:SLOT_W] == PC_NONE) &&
		(out_data_q[SLOT_W-1:0] == out_data_q[RES_BITS-1:RES_BITS-SLOT_W]))
		else $error("summary request with bad terminator or list end");

	a_place_piece: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_kind_q) |-> (out_data_q[SLOT_W+PIECE_W-1:SLOT_W] != PC_NONE))
		else $error("placement request without a piece");

	a_nul_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_axis_tdata == CH_NUL) |=>
		(phase_q == PH_PLACE && slot_q == SLOT_FIRST && rank_q == 3'd7))
		else $error("parser did not restart after end of record");
`endif

endmodule

[tb/tb_fen_position_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FEN position parser testbench
// Streams FEN records one character per request into the parser while an
// independent parser model predicts every placement and summary request.
// A short opening covers early ends and odd board characters. Random records
// follow: mostly well formed with random content, some dense boards that
// overflow the piece list and saturate the clocks, plus noise and truncated
// records. Both sides idle in random bursts, and once the receiver holds
// off long enough that the parser stalls its input.
// ----------------------------------------------------------------------------
module tb_fen_position_parser;
	import fen_pkg::*;

	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          RANDOM_ITEMS   = 600;
	localparam int          TAIL_ITEMS     = 100;
	localparam int          HOLD_CYCLES    = 300;
	localparam int          HOLD_AFTER     = 40;
	localparam int unsigned CLOCK_MAX      = (1 << CLOCK_BITS_DEF) - 1;

	typedef enum logic [3:0] {
		ST_BOARD, ST_SEP, ST_SIDE, ST_SIDE_SKIP, ST_CAS_FIRST, ST_CAS_MORE, ST_CAS_DASH,
		ST_EP_FILE, ST_EP_RANK, ST_EP_SKIP, ST_CLK_FIRST, ST_CLK_SECOND, ST_FIFTY,
		ST_MOVE_WS, ST_MOVE, ST_IGNORE
	} parse_state_t;

	typedef struct {
		logic                 kind;
		logic [SLOT_W-1:0]    slot;
		logic [PIECE_W-1:0]   piece;
		logic [SQ_W-1:0]      square;
		logic                 player;
		logic [CASTLE_W-1:0]  castle;
		logic [EP_W-1:0]      ep_square;
		logic [CLK_OUT_W-1:0] fifty;
		logic [CLK_OUT_W-1:0] fullmove;
		logic [SLOT_W-1:0]    list_end;
	} fen_request_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [CH_W-1:0]    s_axis_tdata = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic               m_axis_tuser;

	fen_position_parser u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser model state
	parse_state_t         parse_state = ST_BOARD;
	logic [2:0]           rank_pos    = 3'd7;
	int                   file_pos    = 0;
	logic [SLOT_W-1:0]    next_slot   = SLOT_FIRST;
	logic                 side_bit    = 1'b0;
	logic [CASTLE_W-1:0]  castle_bits = '0;
	logic [EP_W-1:0]      ep_value    = '0;
	logic [CLK_OUT_W-1:0] fifty_acc   = '0;
	logic [CLK_OUT_W-1:0] move_acc    = '0;
	logic                 move_neg    = 1'b0;
	logic                 move_seen   = 1'b0;
	logic                 clocks_ok   = 1'b0;

	logic [CH_W-1:0] fen_chars[$];
	fen_request_t    expected_requests[$];

	int   err_count    = 0;
	int   results_seen = 0;
	int   idle_cycles  = 0;
	logic tail_part    = 1'b0;

	function automatic logic [PIECE_W-1:0] letter_piece(input logic [CH_W-1:0] c);
		string letters;
		letters = "KQRBNPkqrbnp";
		for (int i = 0; i < 12; i++) begin
			if (letters[i] == c)
				return PIECE_W'(i + 1);
		end
		return PC_NONE;
	endfunction

	function automatic logic [CASTLE_W-1:0] castle_mask(input logic [CH_W-1:0] c);
		case (c)
			"K": return CAS_WK;
			"Q": return CAS_WQ;
			"k": return CAS_BK;
			"q": return CAS_BQ;
			default: return '0;
		endcase
	endfunction

	function automatic bit is_dec(input logic [CH_W-1:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic bit is_ws(input logic [CH_W-1:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic [CLK_OUT_W-1:0] clock_step(input logic [CLK_OUT_W-1:0] acc,
	                                                    input logic [CH_W-1:0] c);
		int unsigned v;
		v = int'(acc) * 10 + int'(c) - int'(CH_0);
		return (v > CLOCK_MAX) ? CLK_OUT_W'(CLOCK_MAX) : CLK_OUT_W'(v);
	endfunction

	task automatic advance_parser(input logic [CH_W-1:0] c);
		fen_request_t        r;
		logic [PIECE_W-1:0]  pc;
		logic [CASTLE_W-1:0] cm;
		r = '{default: '0};
		if (c == CH_NUL) begin
			r.kind      = 1'b1;
			r.slot      = next_slot;
			r.player    = side_bit;
			r.castle    = castle_bits;
			r.ep_square = ep_value;
			r.fifty     = clocks_ok ? fifty_acc : '0;
			r.fullmove  = (clocks_ok && move_seen && !move_neg && move_acc != 0)
			              ? move_acc : CLK_OUT_W'(1);
			r.list_end  = next_slot;
			expected_requests.push_back(r);
			parse_state = ST_BOARD;
			rank_pos    = 3'd7;
			file_pos    = 0;
			next_slot   = SLOT_FIRST;
			side_bit    = 1'b0;
			castle_bits = '0;
			ep_value    = '0;
			fifty_acc   = '0;
			move_acc    = '0;
			move_neg    = 1'b0;
			move_seen   = 1'b0;
			clocks_ok   = 1'b0;
			return;
		end
		case (parse_state)
			ST_BOARD: begin
				pc = letter_piece(c);
				if (pc != PC_NONE) begin
					if (pc == PC_WKING) begin
						r.slot = SLOT_WKING;
					end else if (pc == PC_BKING) begin
						r.slot = SLOT_BKING;
					end else begin
						r.slot = next_slot;
						if (next_slot < SLOT_LIMIT)
							next_slot++;
					end
					r.piece  = pc;
					r.square = {rank_pos, file_pos[2:0]};
					expected_requests.push_back(r);
					file_pos++;
				end else if (c >= CH_1 && c <= CH_8) begin
					file_pos += int'(c - CH_0);
				end else begin
					file_pos++;
				end
				if (file_pos >= 8)
					parse_state = ST_SEP;
			end
			ST_SEP: begin
				if (rank_pos == 0) begin
					parse_state = ST_SIDE;
				end else begin
					rank_pos--;
					file_pos    = 0;
					parse_state = ST_BOARD;
				end
			end
			ST_SIDE: begin
				if (c == "W" || c == "w")
					side_bit = 1'b0;
				else if (c == "B" || c == "b")
					side_bit = 1'b1;
				parse_state = ST_SIDE_SKIP;
			end
			ST_SIDE_SKIP: parse_state = ST_CAS_FIRST;
			ST_CAS_FIRST, ST_CAS_MORE: begin
				cm = castle_mask(c);
				if (parse_state == ST_CAS_FIRST && c == CH_DASH) begin
					parse_state = ST_CAS_DASH;
				end else if (cm != 0) begin
					castle_bits |= cm;
					parse_state = ST_CAS_MORE;
				end else begin
					parse_state = ST_EP_FILE;
				end
			end
			ST_CAS_DASH: parse_state = ST_EP_FILE;
			ST_EP_FILE: begin
				if (c == CH_DASH) begin
					ep_value    = '0;
					parse_state = ST_EP_SKIP;
				end else begin
					ep_value    = (c >= CH_A_LO && c <= CH_H_LO) ? EP_W'(c - CH_A_LO) : '0;
					parse_state = ST_EP_RANK;
				end
			end
			ST_EP_RANK: begin
				if (c >= CH_1 && c <= CH_8)
					ep_value += EP_W'(16 * int'(c - CH_1));
				parse_state = ST_EP_SKIP;
			end
			ST_EP_SKIP: parse_state = ST_CLK_FIRST;
			ST_CLK_FIRST: begin
				if (is_dec(c)) begin
					fifty_acc   = clock_step('0, c);
					parse_state = ST_CLK_SECOND;
				end else begin
					parse_state = ST_IGNORE;
				end
			end
			ST_CLK_SECOND: begin
				if (is_dec(c)) begin
					clocks_ok   = 1'b1;
					fifty_acc   = clock_step(fifty_acc, c);
					parse_state = ST_FIFTY;
				end else if (c == CH_SPACE) begin
					clocks_ok   = 1'b1;
					parse_state = ST_MOVE_WS;
				end else begin
					parse_state = ST_IGNORE;
				end
			end
			ST_FIFTY: begin
				if (is_dec(c))
					fifty_acc = clock_step(fifty_acc, c);
				else if (is_ws(c))
					parse_state = ST_MOVE_WS;
				else
					parse_state = ST_IGNORE;
			end
			ST_MOVE_WS: begin
				if (is_ws(c)) begin
				end else if (c == CH_PLUS) begin
					parse_state = ST_MOVE;
				end else if (c == CH_DASH) begin
					move_neg    = 1'b1;
					parse_state = ST_MOVE;
				end else if (is_dec(c)) begin
					move_acc    = clock_step('0, c);
					move_seen   = 1'b1;
					parse_state = ST_MOVE;
				end else begin
					parse_state = ST_IGNORE;
				end
			end
			ST_MOVE: begin
				if (is_dec(c)) begin
					move_acc  = clock_step(move_acc, c);
					move_seen = 1'b1;
				end else begin
					parse_state = ST_IGNORE;
				end
			end
			default: ;
		endcase
	endtask

	function automatic logic [CH_W-1:0] any_char();
		return CH_W'($urandom_range(1, 255));
	endfunction

	function automatic logic [CH_W-1:0] any_digit();
		return CH_W'(CH_0 + $urandom_range(0, 9));
	endfunction

	// extreme: full board of non-king pieces, all rights, h8, saturating clocks
	task automatic add_record(input bit extreme);
		logic [CH_W-1:0] rec[$];
		int              f;
		int              d;
		int              n;
		int              cut;
		bit              dense;
		string           all_pieces;
		string           fill_pieces;
		string           side_chars;
		string           castle_chars;
		all_pieces   = "KQRBNPkqrbnp";
		fill_pieces  = "QRBNPqrbnp";
		side_chars   = "wbWB";
		castle_chars = "KQkq";
		if (!extreme && $urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 30))
				rec.push_back(any_char());
		end else begin
			dense = extreme || ($urandom_range(0, 7) == 0);
			for (int r = 0; r < 8; r++) begin
				f = 0;
				while (f < 8) begin
					d = $urandom_range(0, 19);
					if (dense) begin
						rec.push_back(fill_pieces[$urandom_range(0, 9)]);
						f++;
					end else if (d < 10) begin
						rec.push_back(all_pieces[$urandom_range(0, 11)]);
						f++;
					end else if (d < 17) begin
						d = $urandom_range(1, 8);
						rec.push_back(CH_W'(CH_0 + d));
						f += d;
					end else begin
						rec.push_back(any_char());
						f++;
					end
				end
				if (!extreme && $urandom_range(0, 15) == 0)
					rec.push_back(any_char());
				else
					rec.push_back((r == 7) ? CH_SPACE : "/");
			end
			if (extreme)
				rec.push_back("B");
			else if ($urandom_range(0, 8) == 0)
				rec.push_back(any_char());
			else
				rec.push_back(side_chars[$urandom_range(0, 3)]);
			rec.push_back(CH_SPACE);
			if (extreme) begin
				for (int i = 0; i < castle_chars.len(); i++)
					rec.push_back(castle_chars[i]);
			end else if ($urandom_range(0, 4) == 0) begin
				rec.push_back(CH_DASH);
			end else begin
				repeat ($urandom_range(0, 5))
					rec.push_back(castle_chars[$urandom_range(0, 3)]);
			end
			rec.push_back(CH_SPACE);
			if (extreme) begin
				rec.push_back(CH_H_LO);
				rec.push_back(CH_8);
			end else if ($urandom_range(0, 1) == 0) begin
				rec.push_back(CH_DASH);
			end else begin
				rec.push_back(($urandom_range(0, 7) == 0) ? any_char()
				              : CH_W'(CH_A_LO + $urandom_range(0, 7)));
				rec.push_back(($urandom_range(0, 7) == 0) ? any_char()
				              : CH_W'(CH_1 + $urandom_range(0, 7)));
			end
			rec.push_back(CH_SPACE);
			if (extreme) begin
				repeat (6) rec.push_back(CH_9);
				rec.push_back(CH_SPACE);
				repeat (6) rec.push_back(CH_9);
			end else if ($urandom_range(0, 9) == 0) begin
				rec.push_back(any_char());
			end else begin
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
				repeat (n) rec.push_back(any_digit());
				repeat ($urandom_range(1, 2))
					rec.push_back(($urandom_range(0, 5) == 0)
					              ? CH_W'(CH_TAB + $urandom_range(0, 4)) : CH_SPACE);
				d = $urandom_range(0, 5);
				if (d == 0)
					rec.push_back(CH_PLUS);
				else if (d == 1)
					rec.push_back(CH_DASH);
				n = ($urandom_range(0, 7) == 0) ? 0
				    : (($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3));
				repeat (n) rec.push_back(any_digit());
				if ($urandom_range(0, 7) == 0)
					rec.push_back(any_char());
			end
			if (!extreme && $urandom_range(0, 7) == 0) begin
				cut = $urandom_range(0, rec.size() - 1);
				while (rec.size() > cut)
					void'(rec.pop_back());
			end
		end
		foreach (rec[i])
			fen_chars.push_back(rec[i]);
		fen_chars.push_back(CH_NUL);
	endtask

	function automatic int idle_rate();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 3;
			default: return 15;
		endcase
	endfunction

	// sender
	int src_gap  = 0;
	int src_rate = 3;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				advance_parser(s_axis_tdata);
			tail_part <= (fen_chars.size() < TAIL_ITEMS);
			if ($urandom_range(0, 127) == 0)
				src_rate <= idle_rate();
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap       <= src_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (!tail_part && src_rate != 0 && $urandom_range(0, src_rate) == 0) begin
					src_gap       <= $urandom_range(0, 12);
					s_axis_tvalid <= 1'b0;
				end else if (fen_chars.size() > 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= fen_chars.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver, with one long hold-off to back the parser up
	int snk_gap   = 0;
	int snk_rate  = 3;
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 127) == 0)
				snk_rate <= idle_rate();
			if (hold_left > 0) begin
				hold_left     <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done     <= 1'b1;
				hold_left     <= HOLD_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else if (snk_gap > 0) begin
				snk_gap       <= snk_gap - 1;
				m_axis_tready <= 1'b0;
			end else if (!tail_part && snk_rate != 0 && $urandom_range(0, snk_rate) == 0) begin
				snk_gap       <= $urandom_range(0, 12);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string name, input longint unsigned want,
	                           input longint unsigned got);
		if (want != got) begin
			$display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin
		fen_request_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen <= results_seen + 1;
			if (expected_requests.size() == 0) begin
				$display("%0t mismatch request: expected none, actual tdata %h tuser %0d",
				         $time, m_axis_tdata, m_axis_tuser);
				err_count++;
			end else begin
				e = expected_requests.pop_front();
				check_field("kind", e.kind, m_axis_tuser);
				check_field("slot", e.slot, m_axis_tdata[6:0]);
				check_field("piece", e.piece, m_axis_tdata[10:7]);
				check_field("square", e.square, m_axis_tdata[16:11]);
				check_field("player", e.player, m_axis_tdata[17]);
				check_field("castle", e.castle, m_axis_tdata[21:18]);
				check_field("ep_square", e.ep_square, m_axis_tdata[28:22]);
				check_field("fifty", e.fifty, m_axis_tdata[44:29]);
				check_field("fullmove", e.fullmove, m_axis_tdata[60:45]);
				check_field("list_end", e.list_end, m_axis_tdata[67:61]);
				check_field("pad", 0, m_axis_tdata[TDATA_W-1:RES_BITS]);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// opening: empty record, duplicate kings and odd board characters ending
	// in the separator, digit overshoot followed by a piece on the next rank
	logic [CH_W-1:0] opening[15] = '{
		CH_NUL,
		"K", "k", 8'hFF, CH_9, "_", CH_0, "K", "k", CH_NUL,
		"3", CH_8, "/", "p", CH_NUL
	};

	initial begin
		foreach (opening[i])
			fen_chars.push_back(opening[i]);
		add_record(1'b1);
		add_record(1'b1);
		while (fen_chars.size() < RANDOM_ITEMS + 15)
			add_record(1'b0);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (fen_chars.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (expected_requests.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0 && expected_requests.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
